### hw/rtl/csim_pkg.sv
// Shared types and constants for the streaming cosine similarity block.
`default_nettype none
package csim_pkg;

  localparam int ElemBits      = 16;
  localparam int AccBits       = 48;
  localparam int NormBits      = 30;
  localparam int SqrtBits      = 2 * NormBits;
  localparam int QuotBits      = 16;
  localparam int QueueDepthDef = 4;

  typedef struct packed {
    logic signed [AccBits-1:0] dot;
    logic [AccBits-1:0]        norm_a;
    logic [AccBits-1:0]        norm_b;
    logic                      degen;
  } csim_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MUL,
    ST_SQRT,
    ST_CAP,
    ST_DIV,
    ST_DONE
  } csim_state_e;

endpackage
`default_nettype wire

### hw/rtl/cosine_similarity_stream.sv
// Top level of the streaming cosine similarity block.
//
// Element pairs enter at one transaction per cycle; the front end multiplies and
// accumulates them, and the item marked last hands the three sums to a queue of
// QUEUE_DEPTH entries. The back end then works on one vector pair at a time: a load
// step, norm scaling, one multiply, 31 square root steps, a range check, 16 division
// steps and a load of the result register, which waits while an untaken result is held;
// a degenerate pair goes from the load straight to the result. Input stalls only when
// queued vectors the back end has not started, plus one being pushed, reach QUEUE_DEPTH,
// so vectors longer than one back end pass stream without a gap.
`default_nettype none
module cosine_similarity_stream import csim_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] a_elem_i,
  input  wire logic signed [15:0] b_elem_i,
  input  wire logic               elem_present_i,
  input  wire logic               is_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      similarity_o,
  output logic                    degenerate_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic accept, pending_last, push, pop, q_empty, q_full;
  logic [CntW-1:0] q_count;
  logic [CntW:0] used;
  csim_job_t front_job, head_job;

  assign used       = {1'b0, q_count} + {{CntW{1'b0}}, pending_last};
  assign in_ready_o = used < (CntW+1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  csim_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .a_elem_i,
    .b_elem_i,
    .elem_present_i,
    .is_last_i,
    .pending_last_o (pending_last),
    .push_o         (push),
    .job_o          (front_job)
  );

  csim_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  csim_back u_back (
    .clk_i,
    .rst_ni,
    .job_i        (head_job),
    .job_valid_i  (!q_empty),
    .pop_o        (pop),
    .out_ready_i,
    .out_valid_o,
    .similarity_o,
    .degenerate_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!q_full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue read while empty");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (similarity_o == 16'sd0))
    else $error("degenerate transaction with nonzero similarity");

endmodule
`default_nettype wire

### hw/rtl/csim_front.sv
// Front end: multiplies element pairs and keeps saturating running sums per vector pair.
`default_nettype none
module csim_front import csim_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic signed [ElemBits-1:0] a_elem_i,
  input  wire logic signed [ElemBits-1:0] b_elem_i,
  input  wire logic                       elem_present_i,
  input  wire logic                       is_last_i,
  output logic                            pending_last_o,
  output logic                            push_o,
  output csim_job_t                       job_o
);

  logic s1_valid_q, s1_last_q, s1_present_q;
  logic signed [2*ElemBits-1:0] prod_ab_q;
  logic [2*ElemBits-1:0] prod_aa_q, prod_bb_q;
  logic signed [AccBits-1:0] dot_q, dot_d, dot_new;
  logic [AccBits-1:0] na_q, na_d, na_new, nb_q, nb_d, nb_new;
  logic any_q, any_d, any_new;
  logic signed [AccBits:0] dot_sum;
  logic [AccBits:0] na_sum, nb_sum;
  logic signed [2*ElemBits-1:0] ab_w, aa_w, bb_w;

  assign ab_w = a_elem_i * b_elem_i;
  assign aa_w = a_elem_i * a_elem_i;
  assign bb_w = b_elem_i * b_elem_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_last_q    <= 1'b0;
      s1_present_q <= 1'b0;
    end else begin
      s1_valid_q   <= accept_i;
      s1_last_q    <= is_last_i;
      s1_present_q <= elem_present_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      prod_ab_q <= ab_w;
      prod_aa_q <= $unsigned(aa_w);
      prod_bb_q <= $unsigned(bb_w);
    end
  end

  assign dot_sum = {dot_q[AccBits-1], dot_q}
                 + {{(AccBits+1-2*ElemBits){prod_ab_q[2*ElemBits-1]}}, prod_ab_q};
  assign na_sum  = {1'b0, na_q} + {{(AccBits+1-2*ElemBits){1'b0}}, prod_aa_q};
  assign nb_sum  = {1'b0, nb_q} + {{(AccBits+1-2*ElemBits){1'b0}}, prod_bb_q};

  always_comb begin
    dot_new = dot_q;
    na_new  = na_q;
    nb_new  = nb_q;
    any_new = any_q;
    if (s1_valid_q && s1_present_q) begin
      if (dot_sum[AccBits] != dot_sum[AccBits-1]) begin
        dot_new = dot_sum[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
      end else begin
        dot_new = dot_sum[AccBits-1:0];
      end
      na_new  = na_sum[AccBits] ? {AccBits{1'b1}} : na_sum[AccBits-1:0];
      nb_new  = nb_sum[AccBits] ? {AccBits{1'b1}} : nb_sum[AccBits-1:0];
      any_new = 1'b1;
    end
  end

  assign push_o         = s1_valid_q && s1_last_q;
  assign pending_last_o = push_o;
  assign job_o.dot      = dot_new;
  assign job_o.norm_a   = na_new;
  assign job_o.norm_b   = nb_new;
  assign job_o.degen    = !any_new || (na_new == '0) || (nb_new == '0);

  always_comb begin
    if (push_o) begin
      dot_d = '0;
      na_d  = '0;
      nb_d  = '0;
      any_d = 1'b0;
    end else begin
      dot_d = dot_new;
      na_d  = na_new;
      nb_d  = nb_new;
      any_d = any_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      any_q <= 1'b0;
    end else begin
      dot_q <= dot_d;
      na_q  <= na_d;
      nb_q  <= nb_d;
      any_q <= any_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/csim_queue.sv
// Small register queue of finished vector sums between the front and back ends.
`default_nettype none
module csim_queue import csim_pkg::*; #(
  parameter int Depth = QueueDepthDef,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  csim_job_t      job_i,
  input  wire logic      pop_i,
  output csim_job_t      job_o,
  output logic           empty_o,
  output logic           full_o,
  output logic [CntW-1:0] count_o
);

  csim_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign job_o   = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/csim_back.sv
// Back end: norm scaling, iterative square root and division, and the result register.
`default_nettype none
module csim_back import csim_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  csim_job_t                job_i,
  input  wire logic                job_valid_i,
  output logic                     pop_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic signed [15:0]       similarity_o,
  output logic                     degenerate_o
);

  localparam int NumW = AccBits + QuotBits + 1;
  localparam int DenW = NormBits + 2;
  localparam int DshW = DenW + QuotBits - 1;

  csim_state_e state_q, state_d;
  logic load_out;

  logic [NumW-1:0] num_q;
  logic neg_q, degen_q, cap_q;
  logic [AccBits-1:0] na_q, nb_q;
  logic [SqrtBits:0] v_q, res_q, bit_q;
  logic [DshW-1:0] dsh_q;
  logic [QuotBits-1:0] quo_q;
  logic [3:0] cnt_q;

  logic sa, sb;
  logic [SqrtBits:0] trial;
  logic [DenW-1:0] den;
  logic [DenW+QuotBits:0] cap_lim;
  logic [QuotBits:0] q_full;
  logic signed [15:0] sim_w;

  assign sa    = |na_q[AccBits-1:NormBits];
  assign sb    = |nb_q[AccBits-1:NormBits];
  assign trial = res_q + bit_q;
  assign den   = (res_q == '0) ? DenW'(2) : {res_q[DenW-2:0], 1'b0};
  assign cap_lim = den * (QuotBits+1)'(32769);
  assign q_full  = cap_q ? (QuotBits+1)'(32768) : {1'b0, quo_q};

  always_comb begin
    if (degen_q) begin
      sim_w = '0;
    end else if (neg_q) begin
      sim_w = 16'(-q_full);
    end else if (q_full[QuotBits:QuotBits-1] != 2'b00) begin
      sim_w = 16'sd32767;
    end else begin
      sim_w = $signed(q_full[15:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = job_i.degen ? ST_DONE : ST_SHIFT;
      ST_SHIFT: if (!sa && !sb) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SQRT;
      ST_SQRT:  if (bit_q[0]) state_d = ST_CAP;
      ST_CAP:   state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: pop_o    = job_valid_i;
      ST_DONE: load_out = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      similarity_o <= sim_w;
      degenerate_o <= degen_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        degen_q <= job_i.degen;
        neg_q   <= job_i.dot[AccBits-1];
        num_q   <= NumW'(job_i.dot[AccBits-1] ? -job_i.dot : job_i.dot);
        na_q    <= job_i.norm_a;
        nb_q    <= job_i.norm_b;
      end
      ST_SHIFT: begin
        if (sa) na_q <= na_q >> 2;
        if (sb) nb_q <= nb_q >> 2;
        num_q <= num_q >> ({1'b0, sa} + {1'b0, sb});
      end
      ST_MUL: begin
        v_q   <= (SqrtBits+1)'(na_q[NormBits-1:0] * nb_q[NormBits-1:0]);
        res_q <= '0;
        bit_q <= (SqrtBits+1)'(1) << SqrtBits;
      end
      ST_SQRT: begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_CAP: begin
        num_q <= (num_q << QuotBits) + NumW'(res_q[NormBits:0]) + NumW'(res_q == '0);
        cap_q <= ((num_q << QuotBits) + NumW'(res_q[NormBits:0]) + NumW'(res_q == '0))
                 >= NumW'(cap_lim);
        dsh_q <= DshW'(den) << (QuotBits - 1);
        cnt_q <= 4'(QuotBits - 1);
        quo_q <= '0;
      end
      ST_DIV: begin
        if (num_q >= NumW'(dsh_q)) begin
          num_q <= num_q - NumW'(dsh_q);
          quo_q <= {quo_q[QuotBits-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QuotBits-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### tb/cosine_similarity_stream_tb.sv
// Self-checking testbench for the streaming cosine similarity block.
`default_nettype none
module cosine_similarity_stream_tb;
  import csim_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int RandItems  = 930;

  typedef struct {
    logic signed [15:0] sim;
    logic               degen;
  } sim_res_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               present;
    logic               last;
    logic               check;
    logic signed [15:0] sim;
    logic               degen;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] a_elem_i = '0;
  logic signed [15:0] b_elem_i = '0;
  logic elem_present_i = 1'b0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] similarity_o;
  logic degenerate_o;

  cosine_similarity_stream dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic signed [47:0] dot_acc;
  logic [47:0]        na_acc;
  logic [47:0]        nb_acc;
  logic               pair_seen;
  sim_res_t           sim_expected[$];
  logic               typed_check[$];
  sim_res_t           typed_val[$];
  int                 mismatches;
  int                 idle_cycles;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] cosine_q15(logic signed [47:0] d, logic [47:0] na,
                                                    logic [47:0] nb);
    logic [63:0] sa, sb, mag, r, q;
    int          ka, kb;
    sa = na;
    sb = nb;
    ka = 0;
    kb = 0;
    while (sa >= (64'd1 << 30)) begin sa = sa >> 2; ka++; end
    while (sb >= (64'd1 << 30)) begin sb = sb >> 2; kb++; end
    mag = d < 0 ? 64'(-{{16{d[47]}}, d}) : 64'(d);
    mag = mag >> (ka + kb);
    r = int_sqrt(sa * sb);
    if (r == 0) r = 1;
    q = (mag * 65536 + r) / (2 * r);
    if (q > 32768) q = 32768;
    if (d < 0) return 16'(-q);
    return q > 32767 ? 16'sd32767 : 16'(q);
  endfunction

  // Models one accepted transaction and queues any result it produces.
  task automatic accumulate_pair(input stim_row_t t);
    logic signed [48:0] s;
    logic [48:0]        ua, ub;
    sim_res_t           res;
    sim_res_t           tv;
    if (t.present) begin
      s = 49'(dot_acc) + 49'(32'(t.a) * 32'(t.b));
      if (s > 49'sh7FFFFFFFFFFF) s = 49'sh7FFFFFFFFFFF;
      if (s < -49'sh800000000000) s = -49'sh800000000000;
      dot_acc = s[47:0];
      ua = {1'b0, na_acc} + 49'(32'(t.a) * 32'(t.a));
      ub = {1'b0, nb_acc} + 49'(32'(t.b) * 32'(t.b));
      na_acc = ua[48] ? '1 : ua[47:0];
      nb_acc = ub[48] ? '1 : ub[47:0];
      pair_seen = 1'b1;
    end
    if (t.last) begin
      if (!pair_seen || na_acc == 0 || nb_acc == 0) begin
        res.sim = 0;
        res.degen = 1'b1;
      end else begin
        res.sim = cosine_q15(dot_acc, na_acc, nb_acc);
        res.degen = 1'b0;
      end
      tv.sim = t.sim;
      tv.degen = t.degen;
      sim_expected.push_back(res);
      typed_check.push_back(t.check);
      typed_val.push_back(tv);
      dot_acc = 0;
      na_acc = 0;
      nb_acc = 0;
      pair_seen = 1'b0;
    end
  endtask

  task automatic send_pair(input stim_row_t t);
    in_valid_i <= 1'b1;
    a_elem_i <= t.a;
    b_elem_i <= t.b;
    elem_present_i <= t.present;
    is_last_i <= t.last;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_pair(t);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic stim_row_t mk(int a, int b, bit p, bit l, bit c = 0, int s = 0,
                                   bit d = 0);
    stim_row_t t;
    t.a = 16'(a);
    t.b = 16'(b);
    t.present = p;
    t.last = l;
    t.check = c;
    t.sim = 16'(s);
    t.degen = d;
    return t;
  endfunction

  stim_row_t directed[$];

  initial begin
    int vec_len;
    int mode;
    stim_row_t t;
    dot_acc = 0;
    na_acc = 0;
    nb_acc = 0;
    pair_seen = 1'b0;
    mismatches = 0;
    directed = '{
      mk(0, 0, 0, 1, 1, 0, 1),
      mk(123, -5, 0, 0),
      mk(0, 0, 0, 1, 1, 0, 1),
      mk(0, 100, 1, 1, 1, 0, 1),
      mk(100, 0, 1, 1, 1, 0, 1),
      mk(32767, 32767, 1, 1, 1, 32767, 0),
      mk(-32768, -32768, 1, 1, 1, 32767, 0),
      mk(-32768, 32767, 1, 1, 1, -32768, 0),
      mk(16384, 16384, 1, 0),
      mk(-16384, 16384, 1, 1, 1, 0, 0),
      mk(1, 1, 1, 0),
      mk(-1, 1, 1, 0),
      mk(0, 0, 0, 0),
      mk(5, 9, 1, 1),
      mk(-1, -1, 1, 1, 1, 32767, 0),
      mk(1, -1, 1, 1, 1, -32768, 0),
      mk(12345, -23456, 1, 0),
      mk(-32768, 32767, 1, 0),
      mk(0, 0, 0, 1)
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_pair(directed[i]);
      sender_gap();
    end
    // A long full-scale vector drives the accumulators to large values.
    for (int i = 0; i < 300; i++) begin
      send_pair(mk(-32768, 32767, 1, i == 299));
      if ($urandom_range(0, 7) == 0) sender_gap();
    end
    for (int n = 0; n < RandItems; n += vec_len) begin
      mode = $urandom_range(0, 9);
      vec_len = mode == 0 ? 1 : $urandom_range(1, mode < 7 ? 8 : 40);
      for (int i = 0; i < vec_len; i++) begin
        t = mk($urandom, $urandom, $urandom_range(0, 19) != 0, i == vec_len - 1);
        if (mode == 1) t.b = t.a;
        if (mode == 2) t.b = -t.a;
        if (mode == 3 && $urandom_range(0, 1)) t.a = 0;
        if (mode == 4) begin
          t.a = 16'($urandom_range(0, 3) - 2);
          t.b = 16'($urandom_range(0, 3) - 2);
        end
        if (mode == 5 && t.last && $urandom_range(0, 2) == 0) t.present = 1'b0;
        send_pair(t);
        if ($urandom_range(0, 2) == 0) sender_gap();
      end
    end
    in_valid_i <= 1'b0;
    while (sim_expected.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Receiver: its own stall pattern, with one long hold-off to fill the sum queue.
  initial begin
    int hold_at;
    hold_at = $urandom_range(400, 900);
    @(posedge rst_ni);
    for (int c = 0; ; c++) begin
      @(posedge clk_i);
      if (c == hold_at) begin
        out_ready_i <= 1'b0;
        repeat (2000) @(posedge clk_i);
      end
      if ((c / 64) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= $urandom_range(0, 2) != 0;
    end
  end

  always @(posedge clk_i) begin
    sim_res_t e;
    sim_res_t tv;
    logic     tc;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sim_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0b", similarity_o, degenerate_o);
      end else begin
        e = sim_expected.pop_front();
        tc = typed_check.pop_front();
        tv = typed_val.pop_front();
        if (tc && (similarity_o !== tv.sim || degenerate_o !== tv.degen)) e = tv;
        if (similarity_o !== e.sim || degenerate_o !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sim %0d degen %0b, got sim %0d degen %0b",
                     e.sim, e.degen, similarity_o, degenerate_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && sim_expected.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
